FILE: design/dmg_pkg.sv
// ----------------------------------------------------------------------------
// dmg_pkg
// Shared types, constants and mode decode for the dropout mask generator.
// ----------------------------------------------------------------------------
package dmg_pkg;

  localparam int WORD_W   = 32;
  localparam int RATE_W   = 5;
  localparam int LEN_W    = 17;
  localparam int COUNT_W  = 6;
  localparam int INDEX_W  = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_TDATA_W = 56;

  localparam logic [LEN_W-1:0]  MAX_UNITS  = LEN_W'(65536);
  localparam logic [RATE_W-1:0] RATE_FULL  = RATE_W'(16);
  localparam logic [RATE_W-1:0] RATE_HALF  = RATE_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DROP_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH      = 2'd2;

  typedef enum logic [6:0] {
    MODE_ONES  = 7'b0000001,
    MODE_ZEROS = 7'b0000010,
    MODE_G4    = 7'b0000100,
    MODE_G3NZ  = 7'b0001000,
    MODE_G2    = 7'b0010000,
    MODE_G3GE3 = 7'b0100000,
    MODE_G1    = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [INDEX_W-1:0] first_index;
    logic [COUNT_W-1:0] unit_count;
    logic [WORD_W-1:0]  mask_bits;
    logic               last_chunk;
  } result_t;

  // rate is already saturated to 0..16
  function automatic mode_t rate_mode(input logic enable, input logic [RATE_W-1:0] rate);
    mode_t m;
    m = MODE_ONES;
    if (enable) begin
      case (rate) inside
        5'd0:             m = MODE_ONES;
        5'd16:            m = MODE_ZEROS;
        5'd1, 5'd15:      m = MODE_G4;
        5'd2, 5'd14:      m = MODE_G3NZ;
        [5'd3:5'd4], [5'd12:5'd13]: m = MODE_G2;
        [5'd5:5'd6], [5'd10:5'd11]: m = MODE_G3GE3;
        default:          m = MODE_G1;
      endcase
    end
    return m;
  endfunction

  function automatic logic [COUNT_W-1:0] mode_units(input mode_t m);
    logic [COUNT_W-1:0] n;
    case (m)
      MODE_G4:    n = COUNT_W'(8);
      MODE_G3NZ:  n = COUNT_W'(10);
      MODE_G2:    n = COUNT_W'(16);
      MODE_G3GE3: n = COUNT_W'(10);
      default:    n = COUNT_W'(32);
    endcase
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] low_ones(input logic [COUNT_W-1:0] n);
    logic [WORD_W:0] one_hot;
    one_hot = (WORD_W+1)'(1) << n;
    return WORD_W'(one_hot - (WORD_W+1)'(1));
  endfunction

endpackage

FILE: design/dropout_mask_generator_top.sv
// ----------------------------------------------------------------------------
// dropout_mask_generator_top
// Turns 32-bit random words into chunks of a dropout activity mask.
// ----------------------------------------------------------------------------
// each result is registered, in the output register or, while output stalls, the skid entry
// throughput: one word per cycle while the skid entry is empty; the next word only needs the chunk position
//   left by the previous one, which updates in the accepting cycle
// an output register plus one skid entry let input take one more word while output stalls
// reset empties both entries, clears the chunk position and sets the config registers to defaults
module dropout_mask_generator_top
  import dmg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [WORD_W-1:0]      s_axis_tdata,  // random_word
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // mask_bits, unit_count, first_index, zero pad
  output logic                   m_axis_tlast   // last_chunk
);

  logic              drop_enable;
  logic [RATE_W-1:0] rate_sixteenths;
  logic [LEN_W-1:0]  vector_length;
  logic [LEN_W-1:0]  unit_position;
  logic [LEN_W-1:0]  unit_position_next;

  result_t out_reg;
  result_t skid_reg;
  result_t res;
  logic    out_valid;
  logic    skid_valid;
  logic    in_fire;
  logic    out_fire;

  logic [RATE_W-1:0]  rate;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   pos;
  logic [LEN_W-1:0]   remaining;
  logic [COUNT_W-1:0] per;
  logic [COUNT_W-1:0] count;
  logic               last;
  logic               invert;
  mode_t              mode;
  logic [WORD_W-1:0]  raw;
  logic [WORD_W-1:0]  word;

  assign word     = s_axis_tdata;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_reg.first_index, out_reg.unit_count, out_reg.mask_bits};
  assign m_axis_tlast  = out_reg.last_chunk;

  always_comb begin
    rate = (rate_sixteenths > RATE_FULL) ? RATE_FULL : rate_sixteenths;
    len  = vector_length;
    if (len == '0) len = LEN_W'(1);
    if (len > MAX_UNITS) len = MAX_UNITS;
    // length lowered mid-vector restarts the vector
    pos = (unit_position >= len) ? '0 : unit_position;

    mode   = rate_mode(drop_enable, rate);
    invert = drop_enable && (rate > RATE_HALF) && (rate < RATE_FULL);
    per    = mode_units(mode);

    remaining = len - pos;
    last      = remaining <= LEN_W'(per);
    count     = last ? remaining[COUNT_W-1:0] : per;
    unit_position_next = last ? '0 : pos + LEN_W'(count);

    raw = '0;
    case (mode)
      MODE_ONES:  raw = '1;
      MODE_ZEROS: raw = '0;
      MODE_G4: begin
        for (int k = 0; k < 8; k++) raw[k] = |word[4*k +: 4];
      end
      MODE_G3NZ: begin
        for (int k = 0; k < 10; k++) raw[k] = |word[3*k +: 3];
      end
      MODE_G2: begin
        for (int k = 0; k < 16; k++) raw[k] = |word[2*k +: 2];
      end
      MODE_G3GE3: begin
        for (int k = 0; k < 10; k++) raw[k] = word[3*k +: 3] >= 3'd3;
      end
      MODE_G1:    raw = word;
      default:    raw = '0;
    endcase

    res.mask_bits   = (invert ? ~raw : raw) & low_ones(count);
    res.unit_count  = count;
    res.first_index = pos[INDEX_W-1:0];
    res.last_chunk  = last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_enable     <= 1'b0;
      rate_sixteenths <= '0;
      vector_length   <= LEN_W'(1);
      unit_position   <= '0;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DROP_ENABLE: drop_enable     <= cfg_data[0];
          REG_RATE:        rate_sixteenths <= cfg_data[RATE_W-1:0];
          REG_LENGTH:      vector_length   <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) unit_position <= unit_position_next;
      if (out_fire || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (in_fire) out_reg <= res;
    end else if (in_fire) begin
      skid_reg <= res;
    end
  end

endmodule

FILE: dv/dropout_mask_generator_top_tb.sv
// ----------------------------------------------------------------------------
// dropout_mask_generator_top_tb
// Feeds random words to the mask generator under a range of drop rates and
// vector lengths, predicts every mask chunk in the bench and compares each
// output item field by field, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module dropout_mask_generator_top_tb
  import dmg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 420;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [WORD_W-1:0]      s_axis_tdata = '0;  // random_word
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // mask_bits, unit_count, first_index, zero pad
  logic                   m_axis_tlast;  // last_chunk

  dropout_mask_generator_top dut (.*);

  // bench copy of the registers and the chunk position
  logic              cfg_enable = 1'b0;
  logic [RATE_W-1:0] cfg_rate = '0;
  logic [LEN_W-1:0]  cfg_length = LEN_W'(1);
  int                unit_pos = 0;

  logic [WORD_W-1:0] random_words[$];
  result_t           pending_chunks[$];
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                errors = 0;
  int                cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [WORD_W-1:0] ones_below(input int n);
    return (n >= 32) ? '1 : ((WORD_W'(1) << n) - WORD_W'(1));
  endfunction

  // works out the chunk for one word and advances the position
  function automatic result_t next_chunk(input logic [WORD_W-1:0] word);
    int rate, len, pos, per, gw, thr, q, t, count, grp;
    logic is_const, const_on, flip, last;
    logic [WORD_W-1:0] mask;
    result_t r;
    rate = (cfg_rate > 16) ? 16 : int'(cfg_rate);
    len = (cfg_length == 0) ? 1 : int'(cfg_length);
    if (len > 65536) len = 65536;
    pos = (unit_pos >= len) ? 0 : unit_pos;
    per = 32;
    gw = 1;
    thr = 1;
    is_const = 1'b0;
    const_on = 1'b1;
    flip = 1'b0;
    if (!cfg_enable || rate == 0) begin
      is_const = 1'b1;
    end else if (rate == 16) begin
      is_const = 1'b1;
      const_on = 1'b0;
    end else begin
      // upper half mirrors the rate and inverts the bits
      flip = (rate > 8);
      q = flip ? 16 - rate : rate;
      if (q == 1) begin
        gw = 4;
        per = 8;
      end else begin
        t = (q + 1) / 2;
        case (t)
          1: begin
            gw = 3;
            per = 10;
          end
          2: begin
            gw = 2;
            per = 16;
          end
          3: begin
            gw = 3;
            per = 10;
            thr = 3;
          end
          default: begin
            gw = 1;
            per = 32;
          end
        endcase
      end
    end
    count = len - pos;
    if (count > per) count = per;
    mask = '0;
    if (is_const) begin
      mask = const_on ? ones_below(count) : '0;
    end else begin
      for (int k = 0; k < count; k++) begin
        grp = int'((word >> (k * gw)) & ((WORD_W'(1) << gw) - WORD_W'(1)));
        if (grp >= thr) mask[k] = 1'b1;
      end
      if (flip) mask = mask ^ ones_below(count);
    end
    last = ((pos + count) == len);
    unit_pos = last ? 0 : pos + count;
    r.first_index = pos[INDEX_W-1:0];
    r.unit_count = count[COUNT_W-1:0];
    r.mask_bits = mask;
    r.last_chunk = last;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (random_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= random_words.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // checks output items, then queues the prediction for an accepted word
  always @(posedge clk) begin : chunk_check
    result_t want;
    logic [WORD_W-1:0]  got_mask;
    logic [COUNT_W-1:0] got_count;
    logic [INDEX_W-1:0] got_index;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_mask = m_axis_tdata[WORD_W-1:0];
        got_count = m_axis_tdata[WORD_W +: COUNT_W];
        got_index = m_axis_tdata[WORD_W+COUNT_W +: INDEX_W];
        if (pending_chunks.size() == 0) begin
          $error("chunk with no word pending: first_index %0d", got_index);
          errors++;
        end else begin
          want = pending_chunks.pop_front();
          if (got_mask !== want.mask_bits) begin
            $error("mask_bits: expected %h, got %h", want.mask_bits, got_mask);
            errors++;
          end
          if (got_count !== want.unit_count) begin
            $error("unit_count: expected %0d, got %0d", want.unit_count, got_count);
            errors++;
          end
          if (got_index !== want.first_index) begin
            $error("first_index: expected %0d, got %0d", want.first_index, got_index);
            errors++;
          end
          if (m_axis_tlast !== want.last_chunk) begin
            $error("last_chunk: expected %0b, got %0b", want.last_chunk, m_axis_tlast);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) pending_chunks.push_back(next_chunk(s_axis_tdata));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dropout_mask_generator_top_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DROP_ENABLE: cfg_enable = val[0];
      REG_RATE:        cfg_rate = val[RATE_W-1:0];
      REG_LENGTH:      cfg_length = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until the sender is empty and every chunk has come back
  task automatic drain();
    do @(negedge clk);
    while (random_words.size() != 0 || s_axis_tvalid || pending_chunks.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // reconfigure while idle, then queue n words
  task automatic run_phase(input logic en, input logic [RATE_W-1:0] rate,
                           input logic [LEN_W-1:0] len, input int n, input bit extremes);
    logic [WORD_W-1:0] a, b;
    drain();
    write_reg(REG_DROP_ENABLE, CFG_W'(en));
    write_reg(REG_RATE, CFG_W'(rate));
    write_reg(REG_LENGTH, CFG_W'(len));
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      a = $urandom;
      b = $urandom;
      if (extremes && i == 0) begin
        random_words.push_back('0);
      end else if (extremes && i == 1) begin
        random_words.push_back('1);
      end else begin
        // sparse and dense words push groups toward the thresholds
        case ($urandom_range(3))
          0: random_words.push_back(a & b);
          1: random_words.push_back(a | b);
          default: random_words.push_back(a);
        endcase
      end
    end
  endtask

  initial begin
    int sent, n, pick;
    logic [RATE_W-1:0] rate;
    logic [LEN_W-1:0] len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: one unit, all active
    @(negedge clk);
    random_words.push_back('0);

    run_phase(1'b1, 5'd1, 17'd20, 3, 1'b1);
    run_phase(1'b1, 5'd2, 17'd10, 2, 1'b1);
    run_phase(1'b1, 5'd4, 17'd16, 2, 1'b1);
    run_phase(1'b1, 5'd6, 17'd10, 2, 1'b1);
    run_phase(1'b1, 5'd8, 17'd32, 2, 1'b1);
    run_phase(1'b1, 5'd15, 17'd8, 2, 1'b1);
    // zero length acts as one unit
    run_phase(1'b1, 5'd10, 17'd0, 2, 1'b1);
    run_phase(1'b1, 5'd16, 17'd40, 2, 1'b1);
    // rate and length both past their maximum, vector left open
    run_phase(1'b1, 5'd31, 17'd131071, 2, 1'b1);
    // disabled with a rate set, position carries over
    run_phase(1'b0, 5'd5, 17'd65536, 1, 1'b0);
    // length dropped below the position restarts at unit zero
    run_phase(1'b1, 5'd3, 17'd5, 1, 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 75;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      rate = ($urandom_range(19) == 0) ? RATE_W'($urandom_range(31, 17))
                                       : RATE_W'($urandom_range(16));
      pick = $urandom_range(99);
      if (pick < 70) len = LEN_W'($urandom_range(64, 1));
      else if (pick < 88) len = LEN_W'($urandom_range(4000, 65));
      else if (pick < 91) len = '0;
      else if (pick < 94) len = MAX_UNITS;
      else if (pick < 96) len = '1;
      else len = LEN_W'($urandom_range(131071, 1));
      n = $urandom_range(30, 5);
      run_phase($urandom_range(7) != 0, rate, len, n, 1'b0);
      sent += n;
    end

    drain();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("dropout_mask_generator_top_tb: clean");
    end else begin
      $display("dropout_mask_generator_top_tb: errors");
    end
    $finish;
  end

endmodule
